// ===== sv/ppi_pkg.sv =====
// Shared types, constants, arctangent table and microcode ROM for the pose integrator.
package ppi_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int CNT_W        = $clog2(ATAN_ENTRIES);
  localparam int UPC_W        = 5;
  localparam int OP_W         = 4;
  localparam int JC_W         = 3;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [JC_W-1:0]  jc_t;
  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // datapath operations
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_CORDIC   = 4'd2;
  localparam op_t OP_MUL_VX   = 4'd3;
  localparam op_t OP_MUL_VY   = 4'd4;
  localparam op_t OP_ROUND_P  = 4'd5;
  localparam op_t OP_MUL_PDT  = 4'd6;
  localparam op_t OP_LOAD_POS = 4'd7;
  localparam op_t OP_DIV_STEP = 4'd8;
  localparam op_t OP_POS_X    = 4'd9;
  localparam op_t OP_POS_Y    = 4'd10;
  localparam op_t OP_MUL_WDT  = 4'd11;
  localparam op_t OP_LOAD_HDG = 4'd12;
  localparam op_t OP_HDG      = 4'd13;
  localparam op_t OP_OUT      = 4'd14;

  // jump conditions
  localparam jc_t JC_NEXT        = 3'd0;
  localparam jc_t JC_GOTO        = 3'd1;
  localparam jc_t JC_ACCEPT      = 3'd2;
  localparam jc_t JC_CORDIC_LOOP = 3'd3;
  localparam jc_t JC_DIV_LOOP    = 3'd4;
  localparam jc_t JC_WAIT_OUT    = 3'd5;

  // microprogram addresses
  localparam upc_t S_LOAD   = 5'd0;
  localparam upc_t S_CORDIC = 5'd1;
  localparam upc_t S_MUL_X  = 5'd2;
  localparam upc_t S_RND_X  = 5'd3;
  localparam upc_t S_PDT_X  = 5'd4;
  localparam upc_t S_LD_X   = 5'd5;
  localparam upc_t S_DIV_X  = 5'd6;
  localparam upc_t S_POS_X  = 5'd7;
  localparam upc_t S_MUL_Y  = 5'd8;
  localparam upc_t S_RND_Y  = 5'd9;
  localparam upc_t S_PDT_Y  = 5'd10;
  localparam upc_t S_LD_Y   = 5'd11;
  localparam upc_t S_DIV_Y  = 5'd12;
  localparam upc_t S_POS_Y  = 5'd13;
  localparam upc_t S_MUL_H  = 5'd14;
  localparam upc_t S_LD_H   = 5'd15;
  localparam upc_t S_DIV_H  = 5'd16;
  localparam upc_t S_HDG    = 5'd17;
  localparam upc_t S_OUT    = 5'd18;

  // serial divider: every divisor is reduced to 15625 after a power-of-two shift
  localparam int DIV_W      = 64;
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = DIV_W / DIV_BITS;
  localparam int DIV_REM_W  = 14;
  localparam logic [DIV_REM_W-1:0] DIV_D = 14'd15625;

  localparam logic [65:0] RND_POS = 66'd128000000;  // half of 256e6
  localparam logic [65:0] RND_HDG = 66'd500000;     // half of 1e6
  localparam int          SH_POS  = 14;             // 256e6 = 2^14 * 15625
  localparam int          SH_HDG  = 6;              // 1e6   = 2^6  * 15625

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic [15:0]        HEADING_RESET   = 16'h4000;

  typedef struct packed {
    op_t  op;
    jc_t  jc;
    upc_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic en;
    cnt_t cnt;
  } ppi_ctrl_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hdg;
  } ppi_pose_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input cnt_t i);
    logic [31:0] r;
    unique case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic uword_t uw(input op_t op, input jc_t jc, input upc_t target);
    uword_t w;
    w.op     = op;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // microcode ROM
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    unique case (a)
      S_LOAD:   w = uw(OP_LOAD,     JC_ACCEPT,      S_OUT);
      S_CORDIC: w = uw(OP_CORDIC,   JC_CORDIC_LOOP, S_CORDIC);
      S_MUL_X:  w = uw(OP_MUL_VX,   JC_NEXT,        S_LOAD);
      S_RND_X:  w = uw(OP_ROUND_P,  JC_NEXT,        S_LOAD);
      S_PDT_X:  w = uw(OP_MUL_PDT,  JC_NEXT,        S_LOAD);
      S_LD_X:   w = uw(OP_LOAD_POS, JC_NEXT,        S_LOAD);
      S_DIV_X:  w = uw(OP_DIV_STEP, JC_DIV_LOOP,    S_DIV_X);
      S_POS_X:  w = uw(OP_POS_X,    JC_NEXT,        S_LOAD);
      S_MUL_Y:  w = uw(OP_MUL_VY,   JC_NEXT,        S_LOAD);
      S_RND_Y:  w = uw(OP_ROUND_P,  JC_NEXT,        S_LOAD);
      S_PDT_Y:  w = uw(OP_MUL_PDT,  JC_NEXT,        S_LOAD);
      S_LD_Y:   w = uw(OP_LOAD_POS, JC_NEXT,        S_LOAD);
      S_DIV_Y:  w = uw(OP_DIV_STEP, JC_DIV_LOOP,    S_DIV_Y);
      S_POS_Y:  w = uw(OP_POS_Y,    JC_NEXT,        S_LOAD);
      S_MUL_H:  w = uw(OP_MUL_WDT,  JC_NEXT,        S_LOAD);
      S_LD_H:   w = uw(OP_LOAD_HDG, JC_NEXT,        S_LOAD);
      S_DIV_H:  w = uw(OP_DIV_STEP, JC_DIV_LOOP,    S_DIV_H);
      S_HDG:    w = uw(OP_HDG,      JC_NEXT,        S_LOAD);
      S_OUT:    w = uw(OP_OUT,      JC_WAIT_OUT,    S_LOAD);
      default:  w = uw(OP_NOP,      JC_GOTO,        S_LOAD);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/planar_pose_integrator.sv =====
// Top level of the dead-reckoning pose integrator: handshakes and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | to block  | in_valid/in_stall  | start_req, time_now, forward_speed, turn_rate
//  out     | from block| out_valid/out_stall| pos_x, pos_y, heading
//
// A moving item runs from accept until its pose is loaded into the result register:
// the CORDIC loop runs one rotation a cycle, then each axis and the heading pass
// through the shared multiplier and the serial divider. A start item goes from its
// load step straight to the result step. The next item is accepted as soon as the result is loaded.
// rst is synchronous: pose returns to the origin facing a quarter turn, no result pending.
// A stalled result holds its register; only the final load step waits on it.
module planar_pose_integrator import ppi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               start_req,
  input  logic [31:0]        time_now,
  input  logic signed [15:0] forward_speed,
  input  logic signed [31:0] turn_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading
);

  ppi_ctrl_t ctrl;
  ppi_pose_t pose;
  logic      in_fire;
  logic      out_free;
  logic      out_load;

  // an item is taken only while the program sits on its load step
  assign in_stall = rst | (ctrl.op != OP_LOAD);
  assign in_fire  = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign out_load = ctrl.en & (ctrl.op == OP_OUT);

  ppi_sequencer #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .start_req(start_req),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  ppi_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .time_now     (time_now),
    .forward_speed(forward_speed),
    .turn_rate    (turn_rate),
    .pose         (pose)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x   <= pose.x;
      pos_y   <= pose.y;
      heading <= pose.hdg;
    end
  end

`ifndef ASSERT_OFF
  a_start_to_out: assert property (@(posedge clk) disable iff (rst)
    in_fire && start_req |=> ctrl.op == OP_OUT)
    else $error("start item did not go straight to result step");
  a_move_to_cordic: assert property (@(posedge clk) disable iff (rst)
    in_fire && !start_req |=> ctrl.op == OP_CORDIC)
    else $error("moving item did not enter the rotation loop");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result loaded but not presented");
`endif

endmodule

// ===== sv/ppi_sequencer.sv =====
// Microcode sequencer: program counter, loop counter and jump logic.
module ppi_sequencer import ppi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      start_req,
  input  logic      out_free,
  output ppi_ctrl_t ctrl
);

  localparam int   NSTEPS      = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam cnt_t CORDIC_LAST = CNT_W'(NSTEPS - 1);
  localparam cnt_t DIV_LAST    = CNT_W'(DIV_CYCLES - 1);

  upc_t   upc;
  upc_t   upc_next;
  cnt_t   cnt;
  cnt_t   cnt_next;
  uword_t word;

  assign word = ucode(upc);

  always_comb begin
    upc_next = upc;
    cnt_next = '0;
    unique case (word.jc)
      JC_NEXT: upc_next = upc + 1'b1;
      JC_GOTO: upc_next = word.target;
      JC_ACCEPT: begin
        if (in_fire) begin
          upc_next = start_req ? word.target : upc + 1'b1;
        end
      end
      JC_CORDIC_LOOP: begin
        if (cnt == CORDIC_LAST) begin
          upc_next = upc + 1'b1;
        end else begin
          upc_next = word.target;
          cnt_next = cnt + 1'b1;
        end
      end
      JC_DIV_LOOP: begin
        if (cnt == DIV_LAST) begin
          upc_next = upc + 1'b1;
        end else begin
          upc_next = word.target;
          cnt_next = cnt + 1'b1;
        end
      end
      JC_WAIT_OUT: begin
        if (out_free) begin
          upc_next = word.target;
        end
      end
      default: upc_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_LOAD;
      cnt <= '0;
    end else begin
      upc <= upc_next;
      cnt <= cnt_next;
    end
  end

  assign ctrl.op  = word.op;
  assign ctrl.cnt = cnt;
  assign ctrl.en  = (word.op == OP_LOAD) ? in_fire :
                    (word.op == OP_OUT)  ? out_free : 1'b1;

`ifndef ASSERT_OFF
  a_cordic_cnt: assert property (@(posedge clk) disable iff (rst)
    word.op == OP_CORDIC |-> cnt <= CORDIC_LAST)
    else $error("cordic step index past last iteration");
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    word.op == OP_DIV_STEP |-> cnt <= DIV_LAST)
    else $error("divider step index past last digit group");
`endif

endmodule

// ===== sv/ppi_datapath.sv =====
// Datapath: pose state, CORDIC rotator, shared multiplier and serial divider.
module ppi_datapath import ppi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ppi_ctrl_t          ctrl,
  input  logic [31:0]        time_now,
  input  logic signed [15:0] forward_speed,
  input  logic signed [31:0] turn_rate,
  output ppi_pose_t          pose
);

  // pose state
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic [15:0]        hdg;
  logic [31:0]        prev_time;

  // per-item working registers
  logic [31:0]        dt;
  logic signed [15:0] spd;
  logic signed [31:0] rate;
  logic signed [32:0] cx;
  logic signed [32:0] cy;
  logic signed [32:0] z;
  logic               flip;
  logic               neg;
  logic [64:0]        mul_res;
  logic [32:0]        p;
  logic [DIV_W-1:0]   div_num;
  logic [DIV_REM_W-1:0] div_rem;

  logic signed [32:0] shx;
  logic signed [32:0] shy;
  logic signed [32:0] atan_ext;
  logic signed [32:0] z_init;
  logic [15:0]        spd_mag;
  logic [31:0]        rate_mag;
  logic [32:0]        cx_mag;
  logic [32:0]        cy_mag;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        mul_prod;
  logic [48:0]        p_round;
  logic [65:0]        rnd_sum;
  logic [DIV_W-1:0]   div_load;
  logic [DIV_W-1:0]   d_num;
  logic [DIV_REM_W-1:0] d_rem;
  logic [DIV_REM_W:0] d_trial;
  logic [15:0]        hq;

  // old position plus or minus a quotient, clamped to the 32-bit range;
  // any quotient of 2^33 or more saturates anyway
  function automatic logic signed [31:0] sat_step(input logic signed [31:0] pos,
                                                  input logic [DIV_W-1:0] q,
                                                  input logic sub);
    logic [32:0]        mag;
    logic signed [34:0] sum;
    logic signed [31:0] r;
    mag = (|q[DIV_W-1:33]) ? {33{1'b1}} : q[32:0];
    sum = sub ? (35'(pos) - $signed({2'b00, mag})) : (35'(pos) + $signed({2'b00, mag}));
    if (sum > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (sum < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = sum[31:0];
    end
    return r;
  endfunction

  assign shx      = cx >>> ctrl.cnt;
  assign shy      = cy >>> ctrl.cnt;
  assign atan_ext = $signed({1'b0, atan_turn(ctrl.cnt)});

  // heading in the left half plane gets a half turn; the top angle bit then equals hdg[14]
  assign z_init = $signed({hdg[14], hdg[14], hdg[14:0], 16'b0});

  assign spd_mag  = spd[15] ? 16'(-spd) : 16'(spd);
  assign rate_mag = rate[31] ? 32'(-rate) : 32'(rate);
  assign cx_mag   = cx[32] ? 33'(-cx) : 33'(cx);
  assign cy_mag   = cy[32] ? 33'(-cy) : 33'(cy);

  always_comb begin
    unique case (ctrl.op)
      OP_MUL_VX: begin
        mul_a = {17'b0, spd_mag};
        mul_b = cx_mag[31:0];
      end
      OP_MUL_VY: begin
        mul_a = {17'b0, spd_mag};
        mul_b = cy_mag[31:0];
      end
      OP_MUL_PDT: begin
        mul_a = p;
        mul_b = dt;
      end
      OP_MUL_WDT: begin
        mul_a = {1'b0, rate_mag};
        mul_b = dt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;
  assign p_round  = mul_res[48:0] + 49'd8192;
  assign rnd_sum  = {1'b0, mul_res} + ((ctrl.op == OP_LOAD_HDG) ? RND_HDG : RND_POS);
  assign div_load = (ctrl.op == OP_LOAD_HDG) ? DIV_W'(rnd_sum[65:SH_HDG])
                                             : DIV_W'(rnd_sum[65:SH_POS]);

  // restoring division by 15625, DIV_BITS quotient bits per cycle
  always_comb begin
    d_num   = div_num;
    d_rem   = div_rem;
    d_trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      d_trial = {d_rem, d_num[DIV_W-1]};
      d_num   = {d_num[DIV_W-2:0], 1'b0};
      if (d_trial >= {1'b0, DIV_D}) begin
        d_rem    = DIV_REM_W'(d_trial - {1'b0, DIV_D});
        d_num[0] = 1'b1;
      end else begin
        d_rem = d_trial[DIV_REM_W-1:0];
      end
    end
  end

  assign hq = div_num[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos     <= '0;
      y_pos     <= '0;
      hdg       <= HEADING_RESET;
      prev_time <= '0;
    end else if (ctrl.en) begin
      unique case (ctrl.op)
        OP_LOAD:  prev_time <= time_now;
        OP_POS_X: x_pos <= sat_step(x_pos, div_num, neg);
        OP_POS_Y: y_pos <= sat_step(y_pos, div_num, neg);
        OP_HDG:   hdg <= rate[31] ? (hdg - hq) : (hdg + hq);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.op)
        OP_LOAD: begin
          dt   <= time_now - prev_time;
          spd  <= forward_speed;
          rate <= turn_rate;
          cx   <= CORDIC_GAIN_Q30;
          cy   <= '0;
          z    <= z_init;
          flip <= hdg[15] ^ hdg[14];
        end
        OP_CORDIC: begin
          if (!z[32]) begin
            cx <= cx - shy;
            cy <= cy + shx;
            z  <= z - atan_ext;
          end else begin
            cx <= cx + shy;
            cy <= cy - shx;
            z  <= z + atan_ext;
          end
        end
        OP_MUL_VX: begin
          mul_res <= mul_prod;
          neg     <= spd[15] ^ cx[32] ^ flip;
        end
        OP_MUL_VY: begin
          mul_res <= mul_prod;
          neg     <= spd[15] ^ cy[32] ^ flip;
        end
        OP_MUL_PDT, OP_MUL_WDT: mul_res <= mul_prod;
        OP_ROUND_P: p <= p_round[46:14];
        OP_LOAD_POS, OP_LOAD_HDG: begin
          div_num <= div_load;
          div_rem <= '0;
        end
        OP_DIV_STEP: begin
          div_num <= d_num;
          div_rem <= d_rem;
        end
        default: ;
      endcase
    end
  end

  assign pose.x   = x_pos;
  assign pose.y   = y_pos;
  assign pose.hdg = hdg;

`ifndef ASSERT_OFF
  a_hdg_hold: assert property (@(posedge clk) disable iff (rst)
    ctrl.op != OP_HDG |=> $stable(hdg))
    else $error("heading changed outside its update step");
  a_x_hold: assert property (@(posedge clk) disable iff (rst)
    ctrl.op != OP_POS_X |=> $stable(x_pos))
    else $error("x position changed outside its update step");
`endif

endmodule

// ===== tb/sv/planar_pose_integrator_tb.sv =====
// Self-checking testbench for the dead-reckoning pose integrator.
`timescale 1ns / 100ps

module planar_pose_integrator_tb;
  import ppi_pkg::*;

  // The DUT runs at its default rotation count; the predictor uses the same.
  localparam int     ROTATIONS = 16;
  // CORDIC gain 0.60725293500888 in Q30: the starting x of every rotation.
  localparam longint KGAIN_Q30 = 64'sd652032874;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               start_req;
  logic [31:0]        time_now;
  logic signed [15:0] forward_speed;
  logic signed [31:0] turn_rate;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;

  planar_pose_integrator #(.CORDIC_STEPS(ROTATIONS)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_req     (start_req),
    .time_now      (time_now),
    .forward_speed (forward_speed),
    .turn_rate     (turn_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading)
  );

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  bit [31:0] arctan_step [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Predicted pose state, tracked in lockstep with accepted items.
  longint    x_est       = 0;
  longint    y_est       = 0;
  bit [15:0] heading_est = 16'h4000;   // reset faces a quarter turn
  bit [31:0] stamp_ref   = 32'd0;      // previous timestamp, zero after reset

  ppi_pose_t poses_due[$];   // predicted poses, oldest first
  int        pose_errors = 0;
  bit        idle_on     = 1'b1;   // random gaps and stalls enabled

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // cos/sin of a binary-angle heading, Q30, by rotation-mode CORDIC.
  // Headings in the left half plane are rotated by a half turn first and the
  // results negated, so the residual angle stays within a quarter turn.
  function automatic void rotate_unit(input bit [15:0] hdg, output longint cs,
                                      output longint sn);
    bit [31:0] ang;
    bit        flip;
    longint    z;
    longint    nx;
    longint    ny;
    ang  = {hdg, 16'h0000};
    flip = (hdg >= 16'h4000) && (hdg < 16'hC000);
    if (flip) ang = ang - 32'h8000_0000;
    z  = longint'($signed(ang));
    cs = KGAIN_Q30;
    sn = 0;
    for (int i = 0; i < ROTATIONS && i < 24; i++) begin
      // >>> on a signed longint is a floor shift
      if (z >= 0) begin
        nx = cs - (sn >>> i);
        ny = sn + (cs >>> i);
        z  = z - longint'(arctan_step[i]);
      end else begin
        nx = cs + (sn >>> i);
        ny = sn - (cs >>> i);
        z  = z + longint'(arctan_step[i]);
      end
      cs = nx;
      sn = ny;
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
  endfunction

  // One axis: |v|*|c| scaled down to Q16, times dt over 256e6,
  // both steps rounded half away from zero, then saturated to 32 bits.
  function automatic longint move_axis(input longint pos, input longint v,
                                       input longint c, input bit [31:0] dt);
    bit        neg;
    bit [63:0] mv;
    bit [63:0] mc;
    bit [63:0] p;
    bit [63:0] d;
    longint    r;
    neg = (v < 0) != (c < 0);
    mv  = (v < 0) ? -v : v;
    mc  = (c < 0) ? -c : c;
    p   = (mv * mc + 64'd8192) >> 14;
    d   = (p * {32'd0, dt} + 64'd128000000) / 64'd256000000;
    r   = neg ? pos - longint'(d) : pos + longint'(d);
    if (r > 64'sd2147483647)  r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // Advance the predicted pose by one accepted item and queue the result.
  function automatic void integrate_pose(input bit st, input bit [31:0] stamp,
                                         input bit signed [15:0] spd,
                                         input bit signed [31:0] rate);
    bit [31:0] dt;
    longint    cs;
    longint    sn;
    bit [63:0] mag;
    bit [15:0] q;
    ppi_pose_t pose;
    if (st) begin
      stamp_ref = stamp;   // reference only, pose untouched
    end else begin
      dt = stamp - stamp_ref;   // modulo 2^32, so counter wrap is harmless
      rotate_unit(heading_est, cs, sn);   // old heading drives the move
      x_est = move_axis(x_est, longint'(spd), cs, dt);
      y_est = move_axis(y_est, longint'(spd), sn, dt);
      mag = (rate < 0) ? -longint'(rate) : longint'(rate);
      q   = 16'((mag * {32'd0, dt} + 64'd500000) / 64'd1000000);
      heading_est = (rate < 0) ? heading_est - q : heading_est + q;
      stamp_ref = stamp;
    end
    pose.x   = 32'(x_est);
    pose.y   = 32'(y_est);
    pose.hdg = heading_est;
    poses_due.push_back(pose);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one item at a falling edge, optionally after a gap, and hold it
  // until the block takes it. Returns at the accepting rising edge; valid
  // stays high so the next call can reuse it without a same-step toggle.
  task automatic offer_sample(input bit st, input bit [31:0] stamp,
                              input bit signed [15:0] spd,
                              input bit signed [31:0] rate);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    start_req     <= st;
    time_now      <= stamp;
    forward_speed <= spd;
    turn_rate     <= rate;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    integrate_pose(st, stamp, spd, rate);
  endtask

  // Move for one second at the given speed while turning exactly onto target:
  // with dt = 1e6 us the heading step equals the rate.
  task automatic turn_to(input bit [15:0] target, input bit signed [15:0] spd);
    bit signed [15:0] diff;
    diff = target - heading_est;
    offer_sample(1'b0, stamp_ref + 32'd1000000, spd, diff);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Random stall bursts while idling is enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, what, want_v, got_v);
      pose_errors++;
    end
  endtask

  // Every accepted pose is compared with the oldest prediction.
  always @(posedge clk) begin : check_pose
    ppi_pose_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (poses_due.size() == 0) begin
        $display("%0t: pose with no item pending, actual x=0x%h y=0x%h heading=0x%h",
                 $time, pos_x, pos_y, heading);
        pose_errors++;
      end else begin
        want = poses_due.pop_front();
        compare_field("pos_x", want.x, pos_x);
        compare_field("pos_y", want.y, pos_y);
        compare_field("heading", {16'd0, want.hdg}, {16'd0, heading});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No start item after reset: dt counts from time zero, heading a quarter turn,
  // so 1 m/s for 1 s should land near y = 1.0.
  task automatic test_first_move_after_reset();
    offer_sample(1'b0, 32'd1000000, 16'sd256, 32'sd0);
  endtask

  // Start items only move the time reference; speed and rate are ignored.
  task automatic test_start_items();
    offer_sample(1'b1, 32'd5000000, 16'sh7FFF, 32'sh7FFFFFFF);
    offer_sample(1'b1, 32'd7000000, -16'sd256, 32'sd9999);
    offer_sample(1'b0, 32'd8000000, -16'sd256, 32'sd16384);
  endtask

  // Visit headings on both sides of every half-plane flip boundary,
  // alternating full forward and full reverse speed.
  task automatic test_quadrants();
    bit [15:0] marks [8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h8000,
                             16'hBFFF, 16'hC000, 16'hFFFF, 16'h2000};
    for (int k = 0; k < 8; k++)
      turn_to(marks[k], (k % 2 != 0) ? 16'sh8000 : 16'sh7FFF);
  endtask

  // dt = 0: nothing may move, even at the extremes of speed and rate.
  task automatic test_equal_timestamps();
    offer_sample(1'b0, stamp_ref, 16'sh7FFF, 32'sh7FFFFFFF);
    offer_sample(1'b1, stamp_ref, 16'sh8000, 32'sh80000000);
    offer_sample(1'b0, stamp_ref, 16'sh8000, 32'sh80000000);
  endtask

  // Timestamp counter rolls over between reference and next item.
  task automatic test_time_wrap();
    offer_sample(1'b1, 32'hFFFF_FF00, 16'sd0, 32'sd0);
    offer_sample(1'b0, 32'h0000_0100, 16'sd5000, -32'sd1000000);
  endtask

  // Maximum dt (reference minus one) at full speed drives each axis into both
  // rails; the full-scale rates wrap the heading many times over.
  task automatic test_saturation_and_wrap();
    turn_to(16'h0000, 16'sd0);
    offer_sample(1'b0, stamp_ref - 32'd1, 16'sh7FFF, 32'sd0);
    offer_sample(1'b0, stamp_ref - 32'd1, 16'sh8000, 32'sh7FFFFFFF);
    turn_to(16'h4000, 16'sd0);
    offer_sample(1'b0, stamp_ref - 32'd1, 16'sh7FFF, 32'sd0);
    offer_sample(1'b0, stamp_ref - 32'd1, 16'sh8000, 32'sh80000000);
  endtask

  // Mostly control-loop traffic (small dt, moderate speed and rate), mixed
  // with start items, repeated stamps, long gaps and fully random items.
  task automatic send_random_item();
    int unsigned      pick;
    bit signed [15:0] spd;
    bit signed [31:0] rate;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) != 0) spd = 16'($urandom);
    else                           spd = 16'(int'($urandom_range(0, 5120)) - 2560);
    if ($urandom_range(0, 1) != 0) rate = 32'($urandom);
    else                           rate = 32'(int'($urandom_range(0, 131072)) - 65536);
    if (pick < 8)       offer_sample(1'b1, $urandom, spd, rate);
    else if (pick < 13) offer_sample(1'b0, $urandom, spd, rate);
    else if (pick < 17) offer_sample(1'b0, stamp_ref, spd, rate);
    else if (pick < 20) offer_sample(1'b0, stamp_ref + $urandom, spd, rate);
    else                offer_sample(1'b0, stamp_ref + $urandom_range(1, 200000), spd, rate);
  endtask

  // Random traffic; every fourth block of 100 items runs without idling.
  task automatic test_random_drive(input int count);
    for (int n = 0; n < count; n++) begin
      idle_on = ((n / 100) % 4) != 3;
      send_random_item();
    end
  endtask

  // Closing stretch at full rate: no gaps, no stalls.
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    start_req     = 1'b0;
    time_now      = 32'd0;
    forward_speed = 16'sd0;
    turn_rate     = 32'sd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_first_move_after_reset();
    test_start_items();
    test_quadrants();
    test_equal_timestamps();
    test_time_wrap();
    test_saturation_and_wrap();
    test_random_drive(1550);
    test_back_to_back(180);

    @(negedge clk);
    in_valid <= 1'b0;
    while (poses_due.size() != 0) @(posedge clk);
    // wait long enough for any stray pose to show up
    repeat (80) @(posedge clk);
    if (pose_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
